/* hdl/qte_pkg.sv */
// qte_pkg: widths, constants and the arctangent table for the quaternion to euler core
// no dependencies
`default_nettype none
package qte_pkg;
    localparam int CORDIC_STEPS = 20;
    localparam int ISQRT_STEPS  = 31;
    localparam int CW           = 38;   // cordic x/y width
    localparam int ZW           = 27;   // angle accumulator width
    localparam int SUMW         = 34;   // width of the atan2 operands
    localparam int RADW         = 61;   // radicand width
    localparam int ROOTW        = 31;   // root width

    localparam logic signed [SUMW-1:0] ONE_Q30 = SUMW'(64'sd1073741824);
    localparam logic signed [ZW-1:0]   HALF_PI = ZW'(32'sd8388608);

    localparam logic [22:0] ATAN_TAB [CORDIC_STEPS] = '{
        23'd4194304, 23'd2476042, 23'd1308273, 23'd664100, 23'd333339,
        23'd166832,  23'd83436,   23'd41721,   23'd20861,  23'd10430,
        23'd5215,    23'd2608,    23'd1304,    23'd652,    23'd326,
        23'd163,     23'd81,      23'd41,      23'd20,     23'd10
    };
endpackage
`default_nettype wire

/* hdl/qte_isqrt.sv */
// qte_isqrt: pipelined integer square root, one result bit per stage
// depends on qte_pkg
`default_nettype none
module qte_isqrt
    import qte_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_vld,
    input  wire logic [RADW-1:0]  i_rad,
    output logic                  o_vld,
    output logic [ROOTW-1:0]      o_root
);
    logic                r_vld [ISQRT_STEPS];
    logic [RADW-1:0]     r_op  [ISQRT_STEPS];
    logic [RADW:0]       r_res [ISQRT_STEPS];

    genvar k;
    generate
        for (k = 0; k < ISQRT_STEPS; k++) begin : g_step
            localparam logic [RADW:0] BIT = (RADW+1)'(1) << (RADW - 1 - 2*k);
            logic              p_vld;
            logic [RADW-1:0]   p_op;
            logic [RADW:0]     p_res;
            logic [RADW:0]     trial;
            logic [RADW-1:0]   n_op;
            logic [RADW:0]     n_res;
            if (k == 0) begin : g_first
                assign p_vld = i_vld;
                assign p_op  = i_rad;
                assign p_res = '0;
            end else begin : g_next
                assign p_vld = r_vld[k-1];
                assign p_op  = r_op[k-1];
                assign p_res = r_res[k-1];
            end
            assign trial = p_res + BIT;
            always_comb begin
                if ({1'b0, p_op} >= trial) begin
                    n_op  = p_op - trial[RADW-1:0];
                    n_res = (p_res >> 1) + BIT;
                end else begin
                    n_op  = p_op;
                    n_res = p_res >> 1;
                end
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else begin
                    r_vld[k] <= p_vld;
                end
                r_op[k]  <= n_op;
                r_res[k] <= n_res;
            end
        end
    endgenerate

    assign o_vld  = r_vld[ISQRT_STEPS-1];
    assign o_root = r_res[ISQRT_STEPS-1][ROOTW-1:0];
endmodule
`default_nettype wire

/* hdl/qte_cordic.sv */
// qte_cordic: pipelined vectoring cordic, atan2(y, x) with 2^24 = pi
// depends on qte_pkg
`default_nettype none
module qte_cordic
    import qte_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_vld,
    input  wire logic signed [CW-1:0] i_x,
    input  wire logic signed [CW-1:0] i_y,
    output logic                      o_vld,
    output logic signed [ZW-1:0]      o_ang
);
    logic                 r_vld  [CORDIC_STEPS+1];
    logic                 r_zero [CORDIC_STEPS+1];
    logic signed [CW-1:0] r_x    [CORDIC_STEPS+1];
    logic signed [CW-1:0] r_y    [CORDIC_STEPS+1];
    logic signed [ZW-1:0] r_z    [CORDIC_STEPS+1];

    // quadrant fold so that x is never negative
    logic signed [CW-1:0] n_x0, n_y0;
    logic signed [ZW-1:0] n_z0;
    always_comb begin
        n_x0 = i_x;
        n_y0 = i_y;
        n_z0 = '0;
        if (i_x < 0) begin
            if (i_y >= 0) begin
                n_x0 = i_y;
                n_y0 = -i_x;
                n_z0 = HALF_PI;
            end else begin
                n_x0 = -i_y;
                n_y0 = i_x;
                n_z0 = -HALF_PI;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
        r_zero[0] <= (i_x == 0) && (i_y == 0);
        r_x[0]    <= n_x0;
        r_y[0]    <= n_y0;
        r_z[0]    <= n_z0;
    end

    genvar i;
    generate
        for (i = 0; i < CORDIC_STEPS; i++) begin : g_iter
            localparam logic signed [ZW-1:0] ANG = ZW'(ATAN_TAB[i]);
            logic signed [CW-1:0] xs, ys;
            assign xs = r_x[i] >>> i;
            assign ys = r_y[i] >>> i;
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[i+1] <= 1'b0;
                end else begin
                    r_vld[i+1] <= r_vld[i];
                end
                r_zero[i+1] <= r_zero[i];
                if (r_y[i] < 0) begin
                    r_x[i+1] <= r_x[i] - ys;
                    r_y[i+1] <= r_y[i] + xs;
                    r_z[i+1] <= r_z[i] - ANG;
                end else begin
                    r_x[i+1] <= r_x[i] + ys;
                    r_y[i+1] <= r_y[i] - xs;
                    r_z[i+1] <= r_z[i] + ANG;
                end
            end
        end
    endgenerate

    assign o_vld = r_vld[CORDIC_STEPS];
    assign o_ang = r_zero[CORDIC_STEPS] ? '0 : r_z[CORDIC_STEPS];
endmodule
`default_nettype wire

/* hdl/quaternion_to_euler_angles_core.sv */
// quaternion_to_euler_angles_core: unit quaternion in q1.15 to roll, pitch, yaw
// depends on qte_pkg, qte_isqrt, qte_cordic
//
//  channel   ports                                     handshake
//  input     i_comp_w/x/y/z                            start, busy
//  result    o_roll_angle, o_pitch_angle, o_yaw_angle, o_done strobe
//            o_pitch_clamped
//
// one word accepted per cycle; busy is always low
// pipeline: products, sums, square, radicand, 31 square root stages, 21 cordic stages, output register
// each stage of the square root and of the cordic is one register
// reset clears only the valid bits; the receiver cannot stall the pipeline
`default_nettype none
module quaternion_to_euler_angles_core
    import qte_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [15:0] i_comp_w,
    input  wire logic signed [15:0] i_comp_x,
    input  wire logic signed [15:0] i_comp_y,
    input  wire logic signed [15:0] i_comp_z,
    output logic                    o_done,
    output logic signed [15:0]      o_roll_angle,
    output logic signed [15:0]      o_pitch_angle,
    output logic signed [15:0]      o_yaw_angle,
    output logic                    o_pitch_clamped
);
    assign busy = 1'b0;

    // stage 1: products
    logic r_v1;
    logic signed [31:0] r_wx, r_yz, r_xx, r_yy, r_wz, r_xy, r_zz, r_wy, r_zx;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
        end
        r_wx <= 32'(i_comp_w) * 32'(i_comp_x);
        r_yz <= 32'(i_comp_y) * 32'(i_comp_z);
        r_xx <= 32'(i_comp_x) * 32'(i_comp_x);
        r_yy <= 32'(i_comp_y) * 32'(i_comp_y);
        r_wz <= 32'(i_comp_w) * 32'(i_comp_z);
        r_xy <= 32'(i_comp_x) * 32'(i_comp_y);
        r_zz <= 32'(i_comp_z) * 32'(i_comp_z);
        r_wy <= 32'(i_comp_w) * 32'(i_comp_y);
        r_zx <= 32'(i_comp_z) * 32'(i_comp_x);
    end

    // stage 2: sums and asin argument saturation
    logic signed [SUMW-1:0] n_sraw;
    assign n_sraw = (SUMW'(r_wy) - SUMW'(r_zx)) <<< 1;
    logic r_v2, r_clamp2;
    logic signed [SUMW-1:0] r_rn2, r_rd2, r_yn2, r_yd2;
    logic signed [31:0]     r_s2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_rn2 <= (SUMW'(r_wx) + SUMW'(r_yz)) <<< 1;
        r_rd2 <= ONE_Q30 - ((SUMW'(r_xx) + SUMW'(r_yy)) <<< 1);
        r_yn2 <= (SUMW'(r_wz) + SUMW'(r_xy)) <<< 1;
        r_yd2 <= ONE_Q30 - ((SUMW'(r_yy) + SUMW'(r_zz)) <<< 1);
        if (n_sraw > ONE_Q30) begin
            r_s2     <= 32'(ONE_Q30);
            r_clamp2 <= 1'b1;
        end else if (n_sraw < -ONE_Q30) begin
            r_s2     <= 32'(-ONE_Q30);
            r_clamp2 <= 1'b1;
        end else begin
            r_s2     <= n_sraw[31:0];
            r_clamp2 <= 1'b0;
        end
    end

    // stage 3: square of the argument, stage 4: radicand
    logic signed [63:0] n_sq;
    assign n_sq = 64'(r_s2) * 64'(r_s2);
    logic r_v3, r_clamp3, r_v4, r_clamp4;
    logic signed [SUMW-1:0] r_rn3, r_rd3, r_yn3, r_yd3, r_rn4, r_rd4, r_yn4, r_yd4;
    logic signed [31:0]     r_s3, r_s4;
    logic [RADW-1:0]        r_sq3, r_rad4;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
        r_sq3    <= n_sq[RADW-1:0];
        r_rn3    <= r_rn2;
        r_rd3    <= r_rd2;
        r_yn3    <= r_yn2;
        r_yd3    <= r_yd2;
        r_s3     <= r_s2;
        r_clamp3 <= r_clamp2;
        r_rad4   <= (RADW'(1) << (RADW-1)) - r_sq3;
        r_rn4    <= r_rn3;
        r_rd4    <= r_rd3;
        r_yn4    <= r_yn3;
        r_yd4    <= r_yd3;
        r_s4     <= r_s3;
        r_clamp4 <= r_clamp3;
    end

    logic             w_sq_vld;
    logic [ROOTW-1:0] w_root;
    qte_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_v4),
        .i_rad   (r_rad4),
        .o_vld   (w_sq_vld),
        .o_root  (w_root)
    );

    // delay line alongside the square root
    logic signed [SUMW-1:0] r_rn_d [ISQRT_STEPS];
    logic signed [SUMW-1:0] r_rd_d [ISQRT_STEPS];
    logic signed [SUMW-1:0] r_yn_d [ISQRT_STEPS];
    logic signed [SUMW-1:0] r_yd_d [ISQRT_STEPS];
    logic signed [31:0]     r_s_d  [ISQRT_STEPS];
    logic                   r_cl_d [ISQRT_STEPS];
    always_ff @(posedge i_clk) begin
        r_rn_d[0] <= r_rn4;
        r_rd_d[0] <= r_rd4;
        r_yn_d[0] <= r_yn4;
        r_yd_d[0] <= r_yd4;
        r_s_d[0]  <= r_s4;
        r_cl_d[0] <= r_clamp4;
        for (int j = 1; j < ISQRT_STEPS; j++) begin
            r_rn_d[j] <= r_rn_d[j-1];
            r_rd_d[j] <= r_rd_d[j-1];
            r_yn_d[j] <= r_yn_d[j-1];
            r_yd_d[j] <= r_yd_d[j-1];
            r_s_d[j]  <= r_s_d[j-1];
            r_cl_d[j] <= r_cl_d[j-1];
        end
    end

    logic w_rv, w_pv, w_yv;
    logic signed [ZW-1:0] w_rz, w_pz, w_yz;
    qte_cordic u_roll (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_vld (w_sq_vld),
        .i_x   (CW'(r_rd_d[ISQRT_STEPS-1])),
        .i_y   (CW'(r_rn_d[ISQRT_STEPS-1])),
        .o_vld (w_rv), .o_ang (w_rz)
    );
    qte_cordic u_pitch (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_vld (w_sq_vld),
        .i_x   ($signed(CW'(w_root))),
        .i_y   (CW'(r_s_d[ISQRT_STEPS-1])),
        .o_vld (w_pv), .o_ang (w_pz)
    );
    qte_cordic u_yaw (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_vld (w_sq_vld),
        .i_x   (CW'(r_yd_d[ISQRT_STEPS-1])),
        .i_y   (CW'(r_yn_d[ISQRT_STEPS-1])),
        .o_vld (w_yv), .o_ang (w_yz)
    );

    logic r_cl_c [CORDIC_STEPS+1];
    always_ff @(posedge i_clk) begin
        r_cl_c[0] <= r_cl_d[ISQRT_STEPS-1];
        for (int j = 1; j <= CORDIC_STEPS; j++) begin
            r_cl_c[j] <= r_cl_c[j-1];
        end
    end

    // rounding to the 16-bit binary angle
    logic signed [ZW:0]   n_rsum, n_psum, n_ysum;
    logic signed [ZW-8:0] n_rb, n_pb, n_yb;
    assign n_rsum = (ZW+1)'(w_rz) + (ZW+1)'(128);
    assign n_psum = (ZW+1)'(w_pz) + (ZW+1)'(128);
    assign n_ysum = (ZW+1)'(w_yz) + (ZW+1)'(128);
    assign n_rb   = n_rsum[ZW:8];
    assign n_pb   = n_psum[ZW:8];
    assign n_yb   = n_ysum[ZW:8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= w_rv && w_pv && w_yv;
        end
        o_roll_angle    <= n_rb[15:0];
        o_yaw_angle     <= n_yb[15:0];
        o_pitch_clamped <= r_cl_c[CORDIC_STEPS];
        if (n_pb > (ZW-7)'(16384)) begin
            o_pitch_angle <= 16'sd16384;
        end else if (n_pb < -(ZW-7)'(16384)) begin
            o_pitch_angle <= -16'sd16384;
        end else begin
            o_pitch_angle <= n_pb[15:0];
        end
    end
endmodule
`default_nettype wire

/* verif/tb_quaternion_to_euler_angles_core.sv */
// testbench for quaternion_to_euler_angles_core: drives quaternions, predicts roll/pitch/yaw
// with a bit-exact cordic/isqrt model and checks each strobed result word in order
// depends on qte_pkg and the core rtl
`timescale 1ns / 1ps
`default_nettype none
module tb_quaternion_to_euler_angles_core;
    import qte_pkg::*;

    typedef struct packed {
        logic signed [15:0] w, x, y, z;
    } quat_t;

    typedef struct packed {
        logic signed [15:0] roll, pitch, yaw;
        logic               clamped;
    } euler_t;

    localparam int LATENCY = 57;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [15:0] i_comp_w = '0, i_comp_x = '0, i_comp_y = '0, i_comp_z = '0;
    logic o_done;
    logic signed [15:0] o_roll_angle, o_pitch_angle, o_yaw_angle;
    logic o_pitch_clamped;

    quat_t  quat_q[$];
    euler_t euler_q[$];
    int     n_mismatch = 0;
    int     n_checked = 0;
    int     n_clamped = 0;
    int     gap = 0;
    bit     stim_done = 1'b0;

    always #6 i_clk = ~i_clk;

    quaternion_to_euler_angles_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_comp_w(i_comp_w), .i_comp_x(i_comp_x), .i_comp_y(i_comp_y),
        .i_comp_z(i_comp_z), .o_done(o_done), .o_roll_angle(o_roll_angle),
        .o_pitch_angle(o_pitch_angle), .o_yaw_angle(o_yaw_angle),
        .o_pitch_clamped(o_pitch_clamped)
    );

    // arithmetic shift right rounds toward minus infinity, same as >>>
    function automatic longint vector_angle(longint yv, longint xv);
        longint ang, xs, ys;
        longint tt;
        ang = 0;
        if (xv == 0 && yv == 0) return 0;
        if (xv < 0) begin
            tt = xv;
            if (yv >= 0) begin
                xv = yv; yv = -tt; ang = 64'sd8388608;
            end else begin
                xv = -yv; yv = tt; ang = -64'sd8388608;
            end
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = xv >>> i;
            ys = yv >>> i;
            if (yv < 0) begin
                xv = xv - ys; yv = yv + xs; ang -= longint'(ATAN_TAB[i]);
            end else begin
                xv = xv + ys; yv = yv - xs; ang += longint'(ATAN_TAB[i]);
            end
        end
        return ang;
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned op, res, b;
        op = n; res = 0; b = 64'd1 << 62;
        while (b > op) b >>= 2;
        while (b != 0) begin
            if (op >= res + b) begin
                op -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic euler_t quat_to_euler(quat_t q);
        longint w, x, y, z, rn, rd, yn, yd, s, c, r, p, yw;
        euler_t e;
        w = q.w; x = q.x; y = q.y; z = q.z;
        e.clamped = 1'b0;
        rn = 2 * (w * x + y * z);
        rd = 64'sd1073741824 - 2 * (x * x + y * y);
        yn = 2 * (w * z + x * y);
        yd = 64'sd1073741824 - 2 * (y * y + z * z);
        s = 2 * (w * y - z * x);
        if (s > 64'sd1073741824) begin
            s = 64'sd1073741824; e.clamped = 1'b1;
        end else if (s < -64'sd1073741824) begin
            s = -64'sd1073741824; e.clamped = 1'b1;
        end
        c = int_sqrt((64'd1 << 60) - longint'(s * s));
        r = (vector_angle(rn, rd) + 128) >>> 8;
        p = (vector_angle(s, c) + 128) >>> 8;
        yw = (vector_angle(yn, yd) + 128) >>> 8;
        if (p > 16384) p = 16384;
        if (p < -16384) p = -16384;
        e.roll = r[15:0];
        e.pitch = p[15:0];
        e.yaw = yw[15:0];
        return e;
    endfunction

    function automatic logic signed [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'($urandom_range(0, 7)) - 16'sd3;
            default: return 16'($urandom);
        endcase
    endfunction

    // random unit-ish quaternion from a crude normalization
    function automatic quat_t rand_unit();
        quat_t q;
        real a, b, cc, d, n;
        a = real'($signed(16'($urandom)));
        b = real'($signed(16'($urandom)));
        cc = real'($signed(16'($urandom)));
        d = real'($signed(16'($urandom)));
        n = $sqrt(a * a + b * b + cc * cc + d * d) + 1.0;
        q.w = 16'($rtoi(a / n * 32767.0));
        q.x = 16'($rtoi(b / n * 32767.0));
        q.y = 16'($rtoi(cc / n * 32767.0));
        q.z = 16'($rtoi(d / n * 32767.0));
        return q;
    endfunction

    // driver: one word per accepted edge, random gaps between words
    always @(posedge i_clk) begin
        if (start && !busy) begin
            euler_q.push_back(quat_to_euler('{i_comp_w, i_comp_x, i_comp_y, i_comp_z}));
        end
        if (!i_rst_n || (start && busy)) begin
            // hold
        end else if (gap > 0) begin
            gap <= gap - 1;
            start <= 1'b0;
        end else if (quat_q.size() > 0) begin
            quat_t q;
            q = quat_q.pop_front();
            {i_comp_w, i_comp_x, i_comp_y, i_comp_z} <= q;
            start <= 1'b1;
            case ($urandom_range(0, 9))
                0, 1, 2: gap <= $urandom_range(1, 3);
                3: gap <= ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80) : 0;
                default: gap <= 0;
            endcase
        end else begin
            start <= 1'b0;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (euler_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected result word at %0t", $realtime);
            end else begin
                euler_t e;
                e = euler_q.pop_front();
                n_checked++;
                if (e.clamped) n_clamped++;
                if (e.roll !== o_roll_angle || e.pitch !== o_pitch_angle
                        || e.yaw !== o_yaw_angle || e.clamped !== o_pitch_clamped) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch exp r=%0d p=%0d y=%0d c=%0b got r=%0d p=%0d y=%0d c=%0b",
                            e.roll, e.pitch, e.yaw, e.clamped, o_roll_angle,
                            o_pitch_angle, o_yaw_angle, o_pitch_clamped);
                end
            end
        end
    end

    initial begin
        quat_t q;
        // directed: identity, extremes, zero operands, pi wrap, gimbal lock, clamp
        quat_q.push_back('{16'sh7fff, 16'sd0, 16'sd0, 16'sd0});
        quat_q.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
        quat_q.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
        quat_q.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
        quat_q.push_back('{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000});
        quat_q.push_back('{16'sd0, 16'sh7fff, 16'sd0, 16'sd0});
        quat_q.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sh7fff});
        quat_q.push_back('{16'sd0, 16'sd0, 16'sh7fff, 16'sd0});
        quat_q.push_back('{16'sd23170, 16'sd0, 16'sd23170, 16'sd0});
        quat_q.push_back('{16'sd23170, 16'sd0, -16'sd23170, 16'sd0});
        quat_q.push_back('{16'sd23170, 16'sd23170, 16'sd0, 16'sd0});
        quat_q.push_back('{16'sd23170, 16'sd0, 16'sd0, -16'sd23170});
        quat_q.push_back('{16'sd30000, 16'sd0, 16'sd30000, 16'sd0});
        quat_q.push_back('{16'sd30000, 16'sd0, -16'sd30000, 16'sd0});
        quat_q.push_back('{16'sd23170, 16'sd23170, 16'sd23170, -16'sd23170});
        quat_q.push_back('{16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384});
        quat_q.push_back('{16'sd0, -16'sd23170, 16'sd0, -16'sd23170});
        quat_q.push_back('{16'sd1, -16'sd1, 16'sd0, 16'sd0});
        quat_q.push_back('{16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa});
        quat_q.push_back('{16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555});
        for (int i = 0; i < 1030; i++) begin
            if ($urandom_range(0, 2) == 0)
                q = '{rand_comp(), rand_comp(), rand_comp(), rand_comp()};
            else
                q = rand_unit();
            quat_q.push_back(q);
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (quat_q.size() == 0 && gap == 0);
        @(posedge i_clk);
        @(posedge i_clk);
        wait (euler_q.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("checked %0d result words, %0d with the pitch clamped", n_checked, n_clamped);
        if (n_mismatch == 0 && euler_q.size() == 0) begin
            $display("PASS quaternion_to_euler_angles_core");
        end else begin
            $display("%0d mismatches", n_mismatch);
            $display("FAIL quaternion_to_euler_angles_core");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("timeout");
        $display("FAIL quaternion_to_euler_angles_core");
        $finish;
    end
endmodule
`default_nettype wire

/* files.f */
hdl/qte_pkg.sv
hdl/qte_isqrt.sv
hdl/qte_cordic.sv
hdl/quaternion_to_euler_angles_core.sv
verif/tb_quaternion_to_euler_angles_core.sv
